[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define UVST_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// Clocked check that also covers the reset cycles.
`define UVST_ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("%m: check failed");

`endif

[hdl/uvst_pkg.sv]
// Types, constants and the arctangent table of the UV sphere tessellator.
package uvst_pkg;

  localparam int IDX_W       = 13;
  localparam int POS_W       = 16;
  localparam int COLOR_W     = 32;
  localparam int RADIUS_W    = 15;
  localparam int CNT_CFG_W   = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 120;

  localparam int MIN_SLICES  = 3;
  localparam int MIN_STACKS  = 2;
  localparam int RESET_GEOM  = 16;

  localparam int TRIG_W      = 18;
  localparam int CORDIC_ITER = 30;
  localparam int CORDIC_W    = 33;
  localparam int CORDIC_ZW   = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 33'sd652032874;

  localparam int MUL_AW = 34;
  localparam int MUL_BW = 18;
  localparam int MUL_PW = MUL_AW + MUL_BW;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STACKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR  = 3'd3;

  localparam logic KIND_VERTEX   = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  typedef enum logic [2:0] {
    PH_RING, PH_NORTH, PH_SOUTH, PH_QUAD, PH_TOP, PH_BOTTOM, PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_PHI_GO, ST_DIV_PHI, ST_DIV_THETA, ST_DISPATCH,
    ST_COR_PHI, ST_COR_THETA, ST_MUL_RS, ST_MUL_X, ST_MUL_Z, ST_MUL_Y,
    ST_MUL_FIN, ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
  } trig_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

[hdl/uv_sphere_tessellator_top.sv]
// UV sphere tessellator top level: sequencer, shared multiplier and output register.
//
// Each input item either restarts the mesh (in_tdata[0] = 1) or steps it, and
// returns at most one result item: ring vertices, then the north and south
// poles, then the quad, top-cap and bottom-cap triangles, the final one with
// tlast set; once the mesh is finished a step returns nothing until a restart.
// A ring vertex makes two 30-iteration passes through the single CORDIC
// rotation unit (polar angle, then azimuth), then four products through the
// single 34x18 multiplier. A restart first runs two serial divisions for the
// angle steps ahead of the first vertex. in_tready is high only while the
// sequencer is idle; a finished result waits in the output register and does
// not block the next item. slices and stacks are latched on restart; radius
// and color are sampled per vertex. Configuration writes are always taken
// (cfg_ready tied high).
module uv_sphere_tessellator_top #(
  parameter int MAX_SLICES = 64,
  parameter int MAX_STACKS = 64,
  parameter int ANGLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [uvst_pkg::IN_TDATA_W-1:0]    in_tdata,   // [0] restart
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [15:0] pos_x, [31:16] pos_y, [47:32] pos_z, [79:48] color,
  // [92:80] index_a, [105:93] index_b, [118:106] index_c
  output logic [uvst_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tuser,  // [0] kind
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [uvst_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uvst_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import uvst_pkg::*;

  localparam int SL_CAP = (MAX_SLICES > RESET_GEOM) ? MAX_SLICES : RESET_GEOM;
  localparam int ST_CAP = (MAX_STACKS > RESET_GEOM) ? MAX_STACKS : RESET_GEOM;
  localparam int SLW    = $clog2(SL_CAP + 2);
  localparam int STW    = $clog2(ST_CAP + 1);
  localparam int DVS_W  = (SLW > STW) ? SLW : STW;
  localparam int CMP_W  = ((DVS_W > CNT_CFG_W) ? DVS_W : CNT_CFG_W) + 1;
  localparam int DVD_W  = ANGLE_BITS + 1;
  localparam logic [DVD_W-1:0] HALF_TURN = DVD_W'(1) << (ANGLE_BITS - 1);
  localparam logic [DVD_W-1:0] FULL_TURN = DVD_W'(1) << ANGLE_BITS;

  // configuration registers
  logic [RADIUS_W-1:0]  radius_r;
  logic [CNT_CFG_W-1:0] num_slices_r, num_stacks_r;
  logic [COLOR_W-1:0]   color_r;

  // sequencer state
  seq_state_t            state_r, state_nxt;
  phase_t                phase_r, phase_nxt;
  logic [SLW-1:0]        eff_sl_r, eff_sl_nxt;
  logic [STW-1:0]        eff_st_r, eff_st_nxt;
  logic [ANGLE_BITS-1:0] phi_step_r, phi_step_nxt;
  logic [ANGLE_BITS-1:0] theta_step_r, theta_step_nxt;
  logic [ANGLE_BITS-1:0] phi_acc_r, phi_acc_nxt;
  logic [ANGLE_BITS-1:0] theta_acc_r, theta_acc_nxt;
  logic [STW-1:0]        ring_r, ring_nxt;
  logic [SLW-1:0]        slice_r, slice_nxt;
  logic                  half_r, half_nxt;
  logic [IDX_W-1:0]      vtx_r, vtx_nxt;
  logic [IDX_W-1:0]      row_r, row_nxt;

  // datapath
  logic signed [TRIG_W-1:0] cp_r, cp_nxt, sp_r, sp_nxt, ct_r, ct_nxt, st_r, st_nxt;
  logic signed [MUL_AW-1:0] m1_r, m1_nxt;
  logic signed [MUL_PW-1:0] prod_r, prod_nxt;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;

  logic                     res_kind_r, res_kind_nxt;
  logic signed [POS_W-1:0]  res_x_r, res_x_nxt, res_y_r, res_y_nxt, res_z_r, res_z_nxt;
  logic [IDX_W-1:0]         res_a_r, res_a_nxt, res_b_r, res_b_nxt, res_c_r, res_c_nxt;
  logic                     res_last_r, res_last_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]   out_data_r, out_data_nxt;
  logic                     out_kind_r, out_kind_nxt;
  logic                     out_last_r, out_last_nxt;

  // shared units
  logic                  cor_start;
  logic [ANGLE_BITS-1:0] cor_angle;
  trig_t                 cor_res;
  logic                  div_start;
  logic [DVD_W-1:0]      div_dividend;
  logic [DVS_W-1:0]      div_divisor;
  logic                  div_done;
  logic [DVD_W-1:0]      div_quo;

  // helpers
  logic [CMP_W-1:0]      ns_ext, nst_ext, sl_clamp, st_clamp;
  logic [SLW-1:0]        slice_inc;
  logic [STW-1:0]        ring_inc;
  logic [IDX_W-1:0]      v_idx, idx_a, idx_b, idx_s, idx_base;
  logic [POS_W-1:0]      rad_pos;
  logic                  emit_go;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [MUL_PW:0] v);
    logic signed [POS_W-1:0] r;
    if (v > (MUL_PW+1)'(32767)) begin
      r = 16'sh7FFF;
    end else if (v < -(MUL_PW+1)'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] round_hi(input logic signed [MUL_PW-1:0] p);
    logic signed [MUL_PW:0] s;
    s = {p[MUL_PW-1], p} + ((MUL_PW+1)'(1) << 31);
    return sat_pos(s >>> 32);
  endfunction

  function automatic logic signed [POS_W-1:0] round_lo(input logic signed [MUL_PW-1:0] p);
    logic signed [MUL_PW:0] s;
    s = {p[MUL_PW-1], p} + ((MUL_PW+1)'(1) << 15);
    return sat_pos(s >>> 16);
  endfunction

  uvst_cordic #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .angle (cor_angle),
    .res   (cor_res)
  );

  uvst_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    ns_ext   = CMP_W'(num_slices_r);
    nst_ext  = CMP_W'(num_stacks_r);
    if (ns_ext < CMP_W'(MIN_SLICES)) begin
      sl_clamp = CMP_W'(MIN_SLICES);
    end else if (ns_ext > CMP_W'(MAX_SLICES)) begin
      sl_clamp = CMP_W'(MAX_SLICES);
    end else begin
      sl_clamp = ns_ext;
    end
    if (nst_ext < CMP_W'(MIN_STACKS)) begin
      st_clamp = CMP_W'(MIN_STACKS);
    end else if (nst_ext > CMP_W'(MAX_STACKS)) begin
      st_clamp = CMP_W'(MAX_STACKS);
    end else begin
      st_clamp = nst_ext;
    end
  end

  assign slice_inc = slice_r + SLW'(1);
  assign ring_inc  = ring_r + STW'(1);
  assign v_idx     = IDX_W'(eff_sl_r) + IDX_W'(1);
  assign idx_s     = IDX_W'(slice_r);
  assign idx_a     = row_r + idx_s;
  assign idx_b     = idx_a + v_idx;
  assign idx_base  = vtx_r - v_idx;
  assign rad_pos   = {1'b0, radius_r};
  assign emit_go   = !out_valid_r || out_tready;

  assign prod_nxt  = mul_a * mul_b;

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    eff_sl_nxt     = eff_sl_r;
    eff_st_nxt     = eff_st_r;
    phi_step_nxt   = phi_step_r;
    theta_step_nxt = theta_step_r;
    phi_acc_nxt    = phi_acc_r;
    theta_acc_nxt  = theta_acc_r;
    ring_nxt       = ring_r;
    slice_nxt      = slice_r;
    half_nxt       = half_r;
    vtx_nxt        = vtx_r;
    row_nxt        = row_r;
    cp_nxt         = cp_r;
    sp_nxt         = sp_r;
    ct_nxt         = ct_r;
    st_nxt         = st_r;
    m1_nxt         = m1_r;
    res_kind_nxt   = res_kind_r;
    res_x_nxt      = res_x_r;
    res_y_nxt      = res_y_r;
    res_z_nxt      = res_z_r;
    res_a_nxt      = res_a_r;
    res_b_nxt      = res_b_r;
    res_c_nxt      = res_c_r;
    res_last_nxt   = res_last_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_kind_nxt   = out_kind_r;
    out_last_nxt   = out_last_r;
    cor_start      = 1'b0;
    cor_angle      = (state_r == ST_DISPATCH) ? phi_acc_r : theta_acc_r;
    div_start      = 1'b0;
    div_dividend   = HALF_TURN + DVD_W'(eff_st_r >> 1);
    div_divisor    = DVS_W'(eff_st_r);
    mul_a          = $signed({{(MUL_AW-RADIUS_W){1'b0}}, radius_r});
    mul_b          = sp_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tdata[0]) begin
            eff_sl_nxt    = SLW'(sl_clamp);
            eff_st_nxt    = STW'(st_clamp);
            phase_nxt     = PH_RING;
            ring_nxt      = '0;
            slice_nxt     = '0;
            half_nxt      = 1'b0;
            vtx_nxt       = '0;
            theta_acc_nxt = '0;
            state_nxt     = ST_DIV_PHI_GO;
          end else begin
            state_nxt = ST_DISPATCH;
          end
        end
      end

      ST_DIV_PHI_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_PHI;
      end

      ST_DIV_PHI: begin
        if (div_done) begin
          phi_step_nxt = div_quo[ANGLE_BITS-1:0];
          phi_acc_nxt  = div_quo[ANGLE_BITS-1:0];
          div_start    = 1'b1;
          div_dividend = FULL_TURN + DVD_W'(eff_sl_r >> 1);
          div_divisor  = DVS_W'(eff_sl_r);
          state_nxt    = ST_DIV_THETA;
        end
      end

      ST_DIV_THETA: begin
        div_dividend = FULL_TURN + DVD_W'(eff_sl_r >> 1);
        div_divisor  = DVS_W'(eff_sl_r);
        if (div_done) begin
          theta_step_nxt = div_quo[ANGLE_BITS-1:0];
          state_nxt      = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        res_a_nxt    = '0;
        res_b_nxt    = '0;
        res_c_nxt    = '0;
        res_last_nxt = 1'b0;
        res_x_nxt    = '0;
        res_y_nxt    = '0;
        res_z_nxt    = '0;
        res_kind_nxt = KIND_TRIANGLE;
        state_nxt    = ST_EMIT;
        unique case (phase_r)
          PH_RING: begin
            cor_start = 1'b1;
            state_nxt = ST_COR_PHI;
          end
          PH_NORTH: begin
            res_kind_nxt = KIND_VERTEX;
            res_y_nxt    = $signed(rad_pos);
          end
          PH_SOUTH: begin
            res_kind_nxt = KIND_VERTEX;
            res_y_nxt    = $signed(POS_W'(0) - rad_pos);
          end
          PH_QUAD: begin
            if (!half_r) begin
              res_a_nxt = idx_a;
              res_b_nxt = idx_a + IDX_W'(1);
              res_c_nxt = idx_b;
            end else begin
              res_a_nxt = idx_b;
              res_b_nxt = idx_a + IDX_W'(1);
              res_c_nxt = idx_b + IDX_W'(1);
            end
          end
          PH_TOP: begin
            res_a_nxt = vtx_r;
            res_b_nxt = idx_s + IDX_W'(1);
            res_c_nxt = idx_s;
          end
          PH_BOTTOM: begin
            res_a_nxt    = vtx_r + IDX_W'(1);
            res_b_nxt    = idx_base + idx_s;
            res_c_nxt    = idx_base + idx_s + IDX_W'(1);
            res_last_nxt = (slice_inc == eff_sl_r);
          end
          PH_DONE: begin
            state_nxt = ST_IDLE;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_COR_PHI: begin
        if (cor_res.done) begin
          cp_nxt    = cor_res.cos_v;
          sp_nxt    = cor_res.sin_v;
          cor_start = 1'b1;
          state_nxt = ST_COR_THETA;
        end
      end

      ST_COR_THETA: begin
        if (cor_res.done) begin
          ct_nxt    = cor_res.cos_v;
          st_nxt    = cor_res.sin_v;
          state_nxt = ST_MUL_RS;
        end
      end

      ST_MUL_RS: begin
        state_nxt = ST_MUL_X;
      end

      ST_MUL_X: begin
        m1_nxt    = prod_r[MUL_AW-1:0];
        mul_a     = prod_r[MUL_AW-1:0];
        mul_b     = ct_r;
        state_nxt = ST_MUL_Z;
      end

      ST_MUL_Z: begin
        res_x_nxt = round_hi(prod_r);
        mul_a     = m1_r;
        mul_b     = st_r;
        state_nxt = ST_MUL_Y;
      end

      ST_MUL_Y: begin
        res_z_nxt = round_hi(prod_r);
        mul_b     = cp_r;
        state_nxt = ST_MUL_FIN;
      end

      ST_MUL_FIN: begin
        res_y_nxt    = round_lo(prod_r);
        res_kind_nxt = KIND_VERTEX;
        res_a_nxt    = '0;
        res_b_nxt    = '0;
        res_c_nxt    = '0;
        res_last_nxt = 1'b0;
        state_nxt    = ST_EMIT;
      end

      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_last_nxt  = res_last_r;
          out_data_nxt  = {1'b0, res_c_r, res_b_r, res_a_r,
                           (res_kind_r == KIND_VERTEX) ? color_r : COLOR_W'(0),
                           res_z_r, res_y_r, res_x_r};
          state_nxt     = ST_IDLE;
          unique case (phase_r)
            PH_RING: begin
              vtx_nxt = vtx_r + IDX_W'(1);
              if (slice_inc > eff_sl_r) begin
                slice_nxt     = '0;
                theta_acc_nxt = '0;
                ring_nxt      = ring_inc;
                phi_acc_nxt   = phi_acc_r + phi_step_r;
                if (ring_inc >= eff_st_r - STW'(1)) begin
                  phase_nxt = PH_NORTH;
                end
              end else begin
                slice_nxt     = slice_inc;
                theta_acc_nxt = theta_acc_r + theta_step_r;
              end
            end
            PH_NORTH: begin
              phase_nxt = PH_SOUTH;
            end
            PH_SOUTH: begin
              phase_nxt = (eff_st_r > STW'(MIN_STACKS)) ? PH_QUAD : PH_TOP;
              ring_nxt  = '0;
              slice_nxt = '0;
              half_nxt  = 1'b0;
              row_nxt   = '0;
            end
            PH_QUAD: begin
              if (!half_r) begin
                half_nxt = 1'b1;
              end else begin
                half_nxt = 1'b0;
                if (slice_inc >= eff_sl_r) begin
                  slice_nxt = '0;
                  row_nxt   = row_r + v_idx;
                  ring_nxt  = ring_inc;
                  if (ring_inc >= eff_st_r - STW'(2)) begin
                    phase_nxt = PH_TOP;
                  end
                end else begin
                  slice_nxt = slice_inc;
                end
              end
            end
            PH_TOP: begin
              if (slice_inc >= eff_sl_r) begin
                slice_nxt = '0;
                phase_nxt = PH_BOTTOM;
              end else begin
                slice_nxt = slice_inc;
              end
            end
            PH_BOTTOM: begin
              if (slice_inc >= eff_sl_r) begin
                slice_nxt = '0;
                phase_nxt = PH_DONE;
              end else begin
                slice_nxt = slice_inc;
              end
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r     <= RADIUS_W'(256);
      num_slices_r <= CNT_CFG_W'(RESET_GEOM);
      num_stacks_r <= CNT_CFG_W'(RESET_GEOM);
      color_r      <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_RADIUS: radius_r     <= cfg_data[RADIUS_W-1:0];
        REG_SLICES: num_slices_r <= cfg_data[CNT_CFG_W-1:0];
        REG_STACKS: num_stacks_r <= cfg_data[CNT_CFG_W-1:0];
        REG_COLOR:  color_r      <= cfg_data[COLOR_W-1:0];
        default: begin
          radius_r <= radius_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_RING;
      eff_sl_r     <= SLW'(RESET_GEOM);
      eff_st_r     <= STW'(RESET_GEOM);
      phi_step_r   <= '0;
      theta_step_r <= '0;
      phi_acc_r    <= '0;
      theta_acc_r  <= '0;
      ring_r       <= '0;
      slice_r      <= '0;
      half_r       <= 1'b0;
      vtx_r        <= '0;
      row_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      eff_sl_r     <= eff_sl_nxt;
      eff_st_r     <= eff_st_nxt;
      phi_step_r   <= phi_step_nxt;
      theta_step_r <= theta_step_nxt;
      phi_acc_r    <= phi_acc_nxt;
      theta_acc_r  <= theta_acc_nxt;
      ring_r       <= ring_nxt;
      slice_r      <= slice_nxt;
      half_r       <= half_nxt;
      vtx_r        <= vtx_nxt;
      row_r        <= row_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r       <= cp_nxt;
    sp_r       <= sp_nxt;
    ct_r       <= ct_nxt;
    st_r       <= st_nxt;
    m1_r       <= m1_nxt;
    prod_r     <= prod_nxt;
    res_kind_r <= res_kind_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    res_z_r    <= res_z_nxt;
    res_a_r    <= res_a_nxt;
    res_b_r    <= res_b_nxt;
    res_c_r    <= res_c_nxt;
    res_last_r <= res_last_nxt;
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

[hdl/uvst_cordic.sv]
// Iterative CORDIC rotation unit: cosine and sine of a binary angle, Q1.16.
module uvst_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [ANGLE_BITS-1:0] angle,
  output uvst_pkg::trig_t       res
);
  import uvst_pkg::*;

  logic [31:0] a_full;
  logic [31:0] a_fold;
  logic [1:0]  quad;
  logic        fold;

  logic signed [CORDIC_W-1:0]  x_r, y_r;
  logic signed [CORDIC_ZW-1:0] z_r;
  logic                        neg_r;
  logic [4:0]                  iter_r;
  logic                        busy_r, fin_r;

  logic signed [CORDIC_W-1:0]  dx, dy, x_nxt, y_nxt;
  logic signed [CORDIC_ZW-1:0] atan_v, z_nxt;
  logic signed [CORDIC_W-1:0]  xs, ys;
  logic signed [CORDIC_W:0]    xr, yr;
  logic                        last_iter;

  assign a_full = {angle, {(32-ANGLE_BITS){1'b0}}};
  assign quad   = a_full[31:30];
  assign fold   = (quad == 2'b01) || (quad == 2'b10);
  assign a_fold = fold ? a_full + 32'h8000_0000 : a_full;

  assign last_iter = (iter_r == 5'(CORDIC_ITER - 1));

  always_comb begin
    dx     = y_r >>> iter_r;
    dy     = x_r >>> iter_r;
    atan_v = $signed({{(CORDIC_ZW-32){1'b0}}, atan_entry(iter_r)});
    if (!z_r[CORDIC_ZW-1]) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - atan_v;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + atan_v;
    end
  end

  // Unfold, then round half up from Q1.30 to Q1.16.
  always_comb begin
    xs = neg_r ? -x_r : x_r;
    ys = neg_r ? -y_r : y_r;
    xr = {xs[CORDIC_W-1], xs} + (CORDIC_W+1)'(8192);
    yr = {ys[CORDIC_W-1], ys} + (CORDIC_W+1)'(8192);
    res.done  = fin_r;
    res.cos_v = xr[14+TRIG_W-1:14];
    res.sin_v = yr[14+TRIG_W-1:14];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      iter_r <= '0;
    end else begin
      fin_r <= !start && busy_r && last_iter;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
      end else if (busy_r) begin
        iter_r <= iter_r + 5'd1;
        if (last_iter) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= CORDIC_X0;
      y_r   <= '0;
      z_r   <= $signed({{(CORDIC_ZW-32){a_fold[31]}}, a_fold});
      neg_r <= fold;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

[hdl/uvst_div.sv]
// Restoring divider, one quotient bit per cycle, for the angle steps.
module uvst_div #(
  parameter int DVD_W = 17,
  parameter int DVS_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);
  import uvst_pkg::*;

  localparam int CW = $clog2(DVD_W + 1);

  logic [CW-1:0]    cnt_r;
  logic             done_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;
  logic             busy;

  assign busy     = (cnt_r != '0);
  assign shifted  = {rem_r, quo_r[DVD_W-1]};
  assign ge       = shifted >= {1'b0, dvs_r};
  assign diff     = shifted - {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy && (cnt_r == CW'(1));
      if (start) begin
        cnt_r <= CW'(DVD_W);
      end else if (busy) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvs_r <= divisor;
      quo_r <= dividend;
    end else if (busy) begin
      rem_r <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

endmodule

[hdl/uvst_checker.sv]
// Port-level checks for the UV sphere tessellator, bound to the top level.
`include "assert_macros.svh"

module uvst_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [uvst_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);

  `UVST_ASSERT_RST(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `UVST_ASSERT_RST(a_one_item, clk, rst_n, in_tvalid && in_tready |=> !in_tready)
  `UVST_ASSERT_RST(a_vtx_clean, clk, rst_n, out_tvalid && !out_tuser |-> out_tdata[118:80] == '0 && !out_tlast)
  `UVST_ASSERT_RST(a_tri_clean, clk, rst_n, out_tvalid && out_tuser |-> out_tdata[79:0] == '0)
  `UVST_ASSERT_CLK(a_reset_idle, clk, !rst_n |=> !out_tvalid && in_tready)

endmodule

bind uv_sphere_tessellator_top uvst_checker u_uvst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
